/* sv/sec_syndrome_decoder_unit_assert.svh */
// assertion macros for the syndrome decoder
`ifndef SEC_SYNDROME_DECODER_UNIT_ASSERT_SVH
`define SEC_SYNDROME_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SECD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("secd assertion failed");

`define SECD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("secd assertion failed");

`else

`define SECD_ASSERT_SAME(lbl, ante, cons)

`define SECD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/secd_pkg.sv */
`timescale 1ns / 1ps

package secd_pkg;

    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_NONE          = 2'd0;
    localparam status_t STATUS_CORRECTED     = 2'd1;
    localparam status_t STATUS_UNCORRECTABLE = 2'd2;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_DATA = 1'b1;

endpackage

/* sv/sec_syndrome_decoder_unit.sv */
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    action, column_index, column_bits, data_byte
// out       output     out_valid/out_ready  out_byte, byte_position, status, error_bit, last_out
// cfg       input      cfg_valid/cfg_ready  cfg_data (detect_only)
//
// a column load is written on acceptance and leaves in_ready high; a codeword chunk
// makes one column memory read per chunk bit on its single read port, then a drain state
// the final chunk adds a decision state, a column search in correct mode, then a read
// and a write state per emitted chunk through the chunk buffer read port
// in_ready is low from acceptance of a chunk until its work is done; emission waits on out_ready
// reset clears syndrome, chunk count and mode; memories hold garbage until written

module sec_syndrome_decoder_unit #(
    parameter int CODE_BITS  = 296,
    parameter int CHECK_BITS = 16,
    parameter int CHUNK_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [$clog2(CODE_BITS)-1:0]        column_index,
    input  logic [CHECK_BITS-1:0]               column_bits,
    input  logic [CHUNK_BITS-1:0]               data_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [CHUNK_BITS-1:0]               out_byte,
    output logic [$clog2(((CODE_BITS + CHUNK_BITS - 1) / CHUNK_BITS) + 1)-1:0] byte_position,
    output secd_pkg::status_t                   status,
    output logic [$clog2(CODE_BITS)-1:0]        error_bit,
    output logic                                last_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data
);

    localparam int NUM_CHUNKS = (CODE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int COL_AW     = $clog2(CODE_BITS);
    localparam int BUF_AW     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int POS_W      = $clog2(NUM_CHUNKS + 1);
    localparam int BIT_W      = $clog2(NUM_CHUNKS * CHUNK_BITS + 1);
    localparam int IDX_W      = (CHUNK_BITS > 1) ? $clog2(CHUNK_BITS) : 1;
    localparam int SCAN_W     = COL_AW + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SYND    = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_CHECK   = 3'd3;
    localparam logic [2:0] S_SEARCH  = 3'd4;
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT_WR = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [CHECK_BITS-1:0]   syn_reg, syn_next;
    logic [POS_W-1:0]        cnt_reg, cnt_next;
    logic [BIT_W-1:0]        base_reg, base_next;
    logic [IDX_W-1:0]        bit_idx_reg, bit_idx_next;
    logic                    pend_reg, pend_next;
    logic [CHUNK_BITS-1:0]   chunk_reg, chunk_next;
    logic                    detect_only_reg, detect_only_next;
    logic [SCAN_W-1:0]       scan_addr_reg, scan_addr_next;
    logic [POS_W-1:0]        scan_chunk_reg, scan_chunk_next;
    logic [IDX_W-1:0]        scan_off_reg, scan_off_next;
    logic                    cmp_pend_reg, cmp_pend_next;
    logic [COL_AW-1:0]       cmp_addr_reg, cmp_addr_next;
    logic [POS_W-1:0]        cmp_chunk_reg, cmp_chunk_next;
    logic [IDX_W-1:0]        cmp_off_reg, cmp_off_next;
    secd_pkg::status_t       stat_reg, stat_next;
    logic [COL_AW-1:0]       err_bit_reg, err_bit_next;
    logic [POS_W-1:0]        err_chunk_reg, err_chunk_next;
    logic [IDX_W-1:0]        err_off_reg, err_off_next;
    logic [POS_W-1:0]        emit_idx_reg, emit_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHUNK_BITS-1:0]   out_byte_reg;
    logic [POS_W-1:0]        out_pos_reg;
    secd_pkg::status_t       out_stat_reg;
    logic [COL_AW-1:0]       out_err_reg;
    logic                    out_last_reg;

    logic                    col_wr_en;
    logic                    col_rd_en;
    logic [COL_AW-1:0]       col_rd_addr;
    logic [CHECK_BITS-1:0]   col_rd_data;
    logic                    buf_wr_en;
    logic                    buf_rd_en;
    logic [CHUNK_BITS-1:0]   buf_rd_data;

    logic                    in_fire;
    logic [BIT_W-1:0]        syn_bit_addr;
    logic                    emit_load;
    logic                    emit_last;
    logic [CHUNK_BITS-1:0]   flip_mask;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign col_wr_en = in_fire && (action == secd_pkg::ACTION_LOAD)
                       && ({1'b0, column_index} < SCAN_W'(CODE_BITS));
    assign buf_wr_en = in_fire && (action == secd_pkg::ACTION_DATA);

    assign syn_bit_addr = base_reg + BIT_W'(bit_idx_reg);
    assign emit_load    = (state_reg == S_EMIT_WR) && (!out_valid_reg || out_ready);
    assign emit_last    = (emit_idx_reg == POS_W'(NUM_CHUNKS - 1));
    assign flip_mask    = ((stat_reg == secd_pkg::STATUS_CORRECTED)
                           && (emit_idx_reg == err_chunk_reg))
                          ? (CHUNK_BITS'(1) << err_off_reg) : '0;

    always_comb
    begin
        col_rd_en   = 1'b0;
        col_rd_addr = '0;
        unique case (state_reg)
            S_SYND:
            begin
                col_rd_en   = 1'b1;
                col_rd_addr = syn_bit_addr[COL_AW-1:0];
            end
            S_SEARCH:
            begin
                col_rd_en   = (scan_addr_reg < SCAN_W'(CODE_BITS));
                col_rd_addr = scan_addr_reg[COL_AW-1:0];
            end
            default:
            begin
                col_rd_en   = 1'b0;
            end
        endcase
    end

    assign buf_rd_en = (state_reg == S_EMIT_RD);

    secd_ram #(
        .WIDTH (CHECK_BITS),
        .DEPTH (CODE_BITS),
        .AW    (COL_AW)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (col_wr_en),
        .wr_addr (column_index),
        .wr_data (column_bits),
        .rd_en   (col_rd_en),
        .rd_addr (col_rd_addr),
        .rd_data (col_rd_data)
    );

    secd_ram #(
        .WIDTH (CHUNK_BITS),
        .DEPTH (NUM_CHUNKS),
        .AW    (BUF_AW)
    ) u_buf_ram (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (cnt_reg[BUF_AW-1:0]),
        .wr_data (data_byte),
        .rd_en   (buf_rd_en),
        .rd_addr (emit_idx_reg[BUF_AW-1:0]),
        .rd_data (buf_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        syn_next         = syn_reg;
        cnt_next         = cnt_reg;
        base_next        = base_reg;
        bit_idx_next     = bit_idx_reg;
        pend_next        = 1'b0;
        chunk_next       = chunk_reg;
        detect_only_next = detect_only_reg;
        scan_addr_next   = scan_addr_reg;
        scan_chunk_next  = scan_chunk_reg;
        scan_off_next    = scan_off_reg;
        cmp_pend_next    = 1'b0;
        cmp_addr_next    = cmp_addr_reg;
        cmp_chunk_next   = cmp_chunk_reg;
        cmp_off_next     = cmp_off_reg;
        stat_next        = stat_reg;
        err_bit_next     = err_bit_reg;
        err_chunk_next   = err_chunk_reg;
        err_off_next     = err_off_reg;
        emit_idx_next    = emit_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cfg_valid && cfg_ready)
        begin
            detect_only_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (buf_wr_en)
                begin
                    chunk_next   = data_byte;
                    bit_idx_next = '0;
                    state_next   = S_SYND;
                end
            end
            S_SYND:
            begin
                // column read issued now, xor applied in the next cycle from the registered read data
                pend_next = chunk_reg[bit_idx_reg]
                            && (syn_bit_addr < BIT_W'(CODE_BITS));
                if (pend_reg)
                begin
                    syn_next = syn_reg ^ col_rd_data;
                end
                bit_idx_next = bit_idx_reg + IDX_W'(1);
                if (bit_idx_reg == IDX_W'(CHUNK_BITS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (pend_reg)
                begin
                    syn_next = syn_reg ^ col_rd_data;
                end
                if (cnt_reg == POS_W'(NUM_CHUNKS - 1))
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cnt_next   = cnt_reg + POS_W'(1);
                    base_next  = base_reg + BIT_W'(CHUNK_BITS);
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                err_bit_next   = '0;
                err_chunk_next = '0;
                err_off_next   = '0;
                emit_idx_next  = '0;
                scan_addr_next = '0;
                scan_chunk_next = '0;
                scan_off_next  = '0;
                priority if (syn_reg == '0)
                begin
                    stat_next  = secd_pkg::STATUS_NONE;
                    state_next = S_EMIT_RD;
                end
                else if (detect_only_reg)
                begin
                    stat_next  = secd_pkg::STATUS_UNCORRECTABLE;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    stat_next  = secd_pkg::STATUS_UNCORRECTABLE;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                priority if (cmp_pend_reg && (col_rd_data == syn_reg))
                begin
                    stat_next      = secd_pkg::STATUS_CORRECTED;
                    err_bit_next   = cmp_addr_reg;
                    err_chunk_next = cmp_chunk_reg;
                    err_off_next   = cmp_off_reg;
                    state_next     = S_EMIT_RD;
                end
                else if (scan_addr_reg == SCAN_W'(CODE_BITS))
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    cmp_pend_next  = 1'b1;
                    cmp_addr_next  = scan_addr_reg[COL_AW-1:0];
                    cmp_chunk_next = scan_chunk_reg;
                    cmp_off_next   = scan_off_reg;
                    scan_addr_next = scan_addr_reg + SCAN_W'(1);
                    if (scan_off_reg == IDX_W'(CHUNK_BITS - 1))
                    begin
                        scan_off_next   = '0;
                        scan_chunk_next = scan_chunk_reg + POS_W'(1);
                    end
                    else
                    begin
                        scan_off_next = scan_off_reg + IDX_W'(1);
                    end
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    if (emit_last)
                    begin
                        syn_next   = '0;
                        cnt_next   = '0;
                        base_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + POS_W'(1);
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            syn_reg         <= '0;
            cnt_reg         <= '0;
            base_reg        <= '0;
            pend_reg        <= 1'b0;
            cmp_pend_reg    <= 1'b0;
            detect_only_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            syn_reg         <= syn_next;
            cnt_reg         <= cnt_next;
            base_reg        <= base_next;
            pend_reg        <= pend_next;
            cmp_pend_reg    <= cmp_pend_next;
            detect_only_reg <= detect_only_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_idx_reg    <= bit_idx_next;
        chunk_reg      <= chunk_next;
        scan_addr_reg  <= scan_addr_next;
        scan_chunk_reg <= scan_chunk_next;
        scan_off_reg   <= scan_off_next;
        cmp_addr_reg   <= cmp_addr_next;
        cmp_chunk_reg  <= cmp_chunk_next;
        cmp_off_reg    <= cmp_off_next;
        stat_reg       <= stat_next;
        err_bit_reg    <= err_bit_next;
        err_chunk_reg  <= err_chunk_next;
        err_off_reg    <= err_off_next;
        emit_idx_reg   <= emit_idx_next;
        if (emit_load)
        begin
            out_byte_reg <= buf_rd_data ^ flip_mask;
            out_pos_reg  <= emit_idx_reg;
            out_stat_reg <= stat_reg;
            out_err_reg  <= err_bit_reg;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_position = out_pos_reg;
    assign status        = out_stat_reg;
    assign error_bit     = out_err_reg;
    assign last_out      = out_last_reg;

`include "sec_syndrome_decoder_unit_assert.svh"

    // only a corrected transaction carries a nonzero error position
    `SECD_ASSERT_SAME(a_err_bit_zero, out_valid && (status != secd_pkg::STATUS_CORRECTED), error_bit == '0)

    `SECD_ASSERT_SAME(a_err_bit_range, out_valid && (status == secd_pkg::STATUS_CORRECTED), {1'b0, error_bit} < SCAN_W'(CODE_BITS))

    // codeword state returns to zero once the final chunk is handed off
    `SECD_ASSERT_NEXT(a_clear_after_emit, emit_load && emit_last, (syn_reg == '0) && (cnt_reg == '0) && out_last_reg)

    // no new chunk is taken while the output still has chunks of a codeword to come
    `SECD_ASSERT_SAME(a_no_input_mid_emit, out_valid && !last_out, !in_ready)

endmodule

/* sv/secd_ram.sv */
`timescale 1ns / 1ps

module secd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 296,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/sv/secd_checker.sv */
`timescale 1ns / 1ps

module secd_checker #(
    parameter int CODE_BITS  = 296,
    parameter int CHECK_BITS = 16,
    parameter int CHUNK_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                action,
    input  logic [$clog2(CODE_BITS)-1:0]        column_index,
    input  logic [CHECK_BITS-1:0]               column_bits,
    input  logic [CHUNK_BITS-1:0]               data_byte,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [CHUNK_BITS-1:0]               out_byte,
    input  logic [$clog2(((CODE_BITS + CHUNK_BITS - 1) / CHUNK_BITS) + 1)-1:0] byte_position,
    input  secd_pkg::status_t                   status,
    input  logic [$clog2(CODE_BITS)-1:0]        error_bit,
    input  logic                                last_out,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic                                cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  words_clean,
    output int                                  words_corrected,
    output int                                  words_flagged
);
    import secd_pkg::*;

    localparam int NUM_CHUNKS = (CODE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int IDX_W      = $clog2(CODE_BITS);
    localparam int POS_W      = $clog2(NUM_CHUNKS + 1);

    typedef struct packed {
        logic [CHUNK_BITS-1:0] byte_val;
        logic [POS_W-1:0]      pos;
        status_t               word_status;
        logic [IDX_W-1:0]      flip_pos;
        logic                  last;
    } chunk_result_t;

    bit [CHECK_BITS-1:0] parity_cols [CODE_BITS];
    bit [CHUNK_BITS-1:0] chunk_store [NUM_CHUNKS];
    bit [CHECK_BITS-1:0] syndrome_acc;
    int                  chunk_fill;
    bit                  detect_mode;
    chunk_result_t       corrected_q [$];
    int                  mismatches = 0;
    int                  n_clean = 0;
    int                  n_corrected = 0;
    int                  n_flagged = 0;

    initial begin
        fail_count      = 0;
        pending         = 0;
        words_clean     = 0;
        words_corrected = 0;
        words_flagged   = 0;
    end

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : decoder_model
        chunk_result_t    rec;
        status_t          word_status;
        int               flip_pos;
        int               bit_pos;
        int               b;
        int               c;
        int               k;
        bit               found;

        if (!rst_n)
        begin
            syndrome_acc = '0;
            chunk_fill   = 0;
            detect_mode  = 1'b0;
            corrected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                detect_mode = cfg_data;

            if (out_valid && out_ready)
            begin
                if (corrected_q.size() == 0)
                begin
                    $error("unexpected transaction: out_byte %0h at position %0d",
                           out_byte, byte_position);
                    mismatches++;
                end
                else
                begin
                    rec = corrected_q.pop_front();
                    check_field("out_byte", rec.byte_val, out_byte);
                    check_field("byte_position", rec.pos, byte_position);
                    check_field("status", rec.word_status, status);
                    check_field("error_bit", rec.flip_pos, error_bit);
                    check_field("last_out", rec.last, last_out);
                end
            end

            if (in_valid && in_ready)
            begin
                if (action == ACTION_LOAD)
                begin
                    if (column_index < CODE_BITS)
                        parity_cols[column_index] = column_bits;
                end
                else
                begin
                    chunk_store[chunk_fill] = data_byte;
                    for (b = 0; b < CHUNK_BITS; b++)
                    begin
                        bit_pos = chunk_fill * CHUNK_BITS + b;
                        if (bit_pos < CODE_BITS && data_byte[b])
                            syndrome_acc ^= parity_cols[bit_pos];
                    end
                    chunk_fill++;

                    if (chunk_fill == NUM_CHUNKS)
                    begin
                        word_status = STATUS_NONE;
                        flip_pos    = 0;
                        found       = 1'b0;
                        if (syndrome_acc != '0)
                        begin
                            word_status = STATUS_UNCORRECTABLE;
                            if (!detect_mode)
                            begin
                                for (c = 0; c < CODE_BITS && !found; c++)
                                begin
                                    if (parity_cols[c] == syndrome_acc)
                                    begin
                                        found       = 1'b1;
                                        flip_pos    = c;
                                        word_status = STATUS_CORRECTED;
                                    end
                                end
                            end
                            if (found)
                                chunk_store[flip_pos / CHUNK_BITS][flip_pos % CHUNK_BITS] ^= 1'b1;
                        end

                        for (k = 0; k < NUM_CHUNKS; k++)
                        begin
                            rec.byte_val    = chunk_store[k];
                            rec.pos         = POS_W'(k);
                            rec.word_status = word_status;
                            rec.flip_pos    = IDX_W'(flip_pos);
                            rec.last        = (k == NUM_CHUNKS - 1);
                            corrected_q.insert(corrected_q.size(), rec);
                        end

                        if (word_status == STATUS_NONE)
                            n_clean++;
                        else if (word_status == STATUS_CORRECTED)
                            n_corrected++;
                        else
                            n_flagged++;

                        syndrome_acc = '0;
                        chunk_fill   = 0;
                    end
                end
            end
        end

        fail_count      <= mismatches;
        pending         <= corrected_q.size();
        words_clean     <= n_clean;
        words_corrected <= n_corrected;
        words_flagged   <= n_flagged;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import secd_pkg::*;

    localparam int CODE_BITS      = 296;
    localparam int CHECK_BITS     = 16;
    localparam int CHUNK_BITS     = 8;
    localparam int NUM_CHUNKS     = (CODE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int MSG_BITS       = CODE_BITS - CHECK_BITS;
    localparam int IDX_W          = $clog2(CODE_BITS);
    localparam int POS_W          = $clog2(NUM_CHUNKS + 1);
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {
        WORD_CLEAN,
        WORD_SINGLE,
        WORD_DOUBLE,
        WORD_GARBAGE
    } word_kind_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   action = ACTION_LOAD;
    logic [IDX_W-1:0]       column_index = '0;
    logic [CHECK_BITS-1:0]  column_bits = '0;
    logic [CHUNK_BITS-1:0]  data_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CHUNK_BITS-1:0]  out_byte;
    logic [POS_W-1:0]       byte_position;
    status_t                status;
    logic [IDX_W-1:0]       error_bit;
    logic                   last_out;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data = 1'b0;

    int                     fail_count;
    int                     pending;
    int                     words_clean;
    int                     words_corrected;
    int                     words_flagged;

    logic [CHECK_BITS-1:0]  column_shadow [CODE_BITS];
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     quiet_cycles = 0;
    int                     n_loads = 0;

    sec_syndrome_decoder_unit #(
        .CODE_BITS  (CODE_BITS),
        .CHECK_BITS (CHECK_BITS),
        .CHUNK_BITS (CHUNK_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .column_index  (column_index),
        .column_bits   (column_bits),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_position (byte_position),
        .status        (status),
        .error_bit     (error_bit),
        .last_out      (last_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    secd_checker #(
        .CODE_BITS  (CODE_BITS),
        .CHECK_BITS (CHECK_BITS),
        .CHUNK_BITS (CHUNK_BITS)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .column_index    (column_index),
        .column_bits     (column_bits),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .byte_position   (byte_position),
        .status          (status),
        .error_bit       (error_bit),
        .last_out        (last_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .words_clean     (words_clean),
        .words_corrected (words_corrected),
        .words_flagged   (words_flagged)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("sec_syndrome_decoder_unit regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [CHECK_BITS-1:0] bits,
                             input logic [CHUNK_BITS-1:0] chunk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        column_index <= idx;
        column_bits  <= bits;
        data_byte    <= chunk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic load_column(input int idx, input logic [CHECK_BITS-1:0] bits);
        if (idx < CODE_BITS)
            column_shadow[idx] = bits;
        n_loads++;
        send_item(ACTION_LOAD, IDX_W'(idx), bits, CHUNK_BITS'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_detect_only(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // data bits are random, check bits cancel the data syndrome on the identity tail
    task automatic send_codeword(input word_kind_e kind);
        logic [CODE_BITS-1:0]  cw;
        logic [CHECK_BITS-1:0] syn;
        int                    i;
        int                    k;
        int                    flip_a;
        int                    flip_b;
        int                    load_at;

        cw  = '0;
        syn = '0;
        for (i = 0; i < MSG_BITS; i++)
        begin
            cw[i] = $urandom_range(0, 1);
            if (cw[i])
                syn ^= column_shadow[i];
        end
        cw[CODE_BITS-1 -: CHECK_BITS] = syn;

        flip_a = $urandom_range(0, CODE_BITS - 1);
        do
            flip_b = $urandom_range(0, CODE_BITS - 1);
        while (flip_b == flip_a);

        case (kind)
            WORD_SINGLE:
                cw[flip_a] = ~cw[flip_a];
            WORD_DOUBLE:
            begin
                cw[flip_a] = ~cw[flip_a];
                cw[flip_b] = ~cw[flip_b];
            end
            WORD_GARBAGE:
                for (k = 0; k < NUM_CHUNKS; k++)
                begin
                    case ($urandom_range(0, 7))
                        0:       cw[k*CHUNK_BITS +: CHUNK_BITS] = '0;
                        1:       cw[k*CHUNK_BITS +: CHUNK_BITS] = '1;
                        default: cw[k*CHUNK_BITS +: CHUNK_BITS] = CHUNK_BITS'($urandom);
                    endcase
                end
            default: ;
        endcase

        // column rewrite in the middle of a codeword
        load_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NUM_CHUNKS - 1) : -1;

        for (k = 0; k < NUM_CHUNKS; k++)
        begin
            if (k == load_at)
                load_column($urandom_range(0, MSG_BITS - 1), CHECK_BITS'($urandom));
            send_item(ACTION_DATA, IDX_W'($urandom), CHECK_BITS'($urandom),
                      cw[k*CHUNK_BITS +: CHUNK_BITS]);
        end
    endtask

    initial
    begin : stimulus
        logic [CHECK_BITS-1:0] col;
        int                    c;
        int                    mix;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_detect_only(1'b0);

        for (mix = 0; mix < 4; mix++)
        begin
            wait_idle();
            write_detect_only(mix == 3);
            case (mix)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 51;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct <= 36;
                end
            endcase

            if (mix < 2)
            begin
                // random matrix with some repeated columns, identity on the check bits
                for (c = mix * (CODE_BITS / 2); c < ((mix == 0) ? CODE_BITS / 2 : CODE_BITS);
                     c++)
                begin
                    if (c >= MSG_BITS)
                    begin
                        col = '0;
                        col[c - MSG_BITS] = 1'b1;
                    end
                    else if (c >= 8 && $urandom_range(0, 9) == 0)
                        col = column_shadow[$urandom_range(0, c - 1)];
                    else
                        col = CHECK_BITS'($urandom_range(1, (1 << CHECK_BITS) - 1));
                    load_column(c, col);
                end
            end

            if (mix == 1)
            begin
                load_column(CODE_BITS, '1);
                load_column((1 << IDX_W) - 1, 16'habcd);
                load_column(MSG_BITS - 1, '1);
                load_column(0, '0);
                load_column(1, column_shadow[MSG_BITS]);
                load_column(40, column_shadow[100]);
            end

            if (mix >= 2)
                send_codeword(WORD_SINGLE);
        end

        wait_idle();
        recv_stall_pct <= 0;

        $display("covered %0d codewords (%0d clean, %0d corrected, %0d uncorrectable)",
                 words_clean + words_corrected + words_flagged, words_clean,
                 words_corrected, words_flagged);
        $display("with %0d column loads, detect-only off and on, four handshake mixes",
                 n_loads);
        if (fail_count == 0 && pending == 0)
            $display("sec_syndrome_decoder_unit regression: pass");
        else
            $display("sec_syndrome_decoder_unit regression: fail");
        $finish;
    end

endmodule
